### rtl/core/acpu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acpu_pkg: shared types and constants of the accumulator processor
// Word layouts of both channels, command and opcode codes, processor state
// record and the small remainder tables used for address wrapping.
// ----------------------------------------------------------------------------
package acpu_pkg;

    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned MEM_DEPTH_DEF  = 256;
    localparam int unsigned PORT_COUNT_DEF = 8;
    localparam int unsigned RAM_DEPTH_DEF  = MEM_DEPTH_DEF + PORT_COUNT_DEF;
    localparam int unsigned TBL_SIZE       = 256;

    // Commands carried by an input word
    typedef enum logic [1:0] {
        CMD_MEM_WR  = 2'd0,
        CMD_PORT_WR = 2'd1,
        CMD_PORT_RD = 2'd2,
        CMD_EXEC    = 2'd3
    } t_cmd;

    // Processor run status
    typedef enum logic [1:0] {
        RUN_ACTIVE  = 2'd0,
        RUN_HALTED  = 2'd1,
        RUN_INVALID = 2'd2
    } t_run;

    // Sequencer of the execute stage
    typedef enum logic [1:0] {
        SEQ_EMPTY,
        SEQ_BUSY,
        SEQ_PORT_WAIT
    } t_seq;

    // Opcodes
    localparam logic [7:0] OP_NOP  = 8'h00;
    localparam logic [7:0] OP_ADD  = 8'h01;
    localparam logic [7:0] OP_SUB  = 8'h02;
    localparam logic [7:0] OP_OUT  = 8'h03;
    localparam logic [7:0] OP_IN   = 8'h04;
    localparam logic [7:0] OP_JZ   = 8'h05;
    localparam logic [7:0] OP_JC   = 8'h06;
    localparam logic [7:0] OP_JMP  = 8'h07;
    localparam logic [7:0] OP_HALT = 8'hFF;

    typedef struct packed {
        t_cmd       command;
        logic [7:0] address;
        logic [7:0] data;
    } t_in_word;

    typedef struct packed {
        logic [7:0] acc_value;
        logic [7:0] pc_value;
        logic       carry_out;
        logic       zero_out;
        logic [1:0] run_status;
        logic       port_write_valid;
        logic [2:0] port_write_index;
        logic [7:0] port_write_value;
        logic [7:0] read_value;
    } t_out_word;

    // Architectural registers of the processor
    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] pc;
        logic       carry;
        logic       zero;
        t_run       status;
    } t_arch;

    // Outcome of one instruction
    typedef struct packed {
        t_arch nxt;
        logic  port_wr;
        logic  port_rd;
    } t_alu_res;

    // Byte value to remainder, one entry per byte value
    typedef logic [TBL_SIZE-1:0][7:0] t_mod_tbl;

    function automatic t_mod_tbl mod_table(input int unsigned modulus);
        t_mod_tbl    tbl;
        int unsigned rem;
        rem = 0;
        for (int i = 0; i < TBL_SIZE; i++) begin
            tbl[i] = 8'(rem);
            rem    = rem + 1;
            if (rem == modulus) begin
                rem = 0;
            end
        end
        return tbl;
    endfunction

endpackage
`default_nettype wire

### rtl/core/acpu_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acpu_ram: generic synchronous RAM
// One write port and two read ports sharing one enable, registered read.
// ----------------------------------------------------------------------------
module acpu_ram
    import acpu_pkg::*;
#(
    parameter  int unsigned WIDTH = BYTE_W,
    parameter  int unsigned DEPTH = RAM_DEPTH_DEF,
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr0,
    input  wire logic [AW-1:0]    i_raddr1,
    output logic      [WIDTH-1:0] o_rdata0,
    output logic      [WIDTH-1:0] o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata0;
    logic [WIDTH-1:0] r_rdata1;

    // Write, and read into the output registers; a read of the address being written returns the old byte
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata0 <= r_mem[i_raddr0];
            r_rdata1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule
`default_nettype wire

### rtl/core/acpu_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acpu_alu: instruction execute
// Decodes one opcode with its operand byte and forms the next register set,
// plus the port write and port read requests.
// ----------------------------------------------------------------------------
module acpu_alu
    import acpu_pkg::*;
(
    input  wire t_arch      i_arch,
    input  wire logic [7:0] i_op,
    input  wire logic [7:0] i_arg,
    output t_alu_res        o_res
);

    logic [8:0] sum;
    logic [7:0] diff;
    logic [7:0] pc_one;
    logic [7:0] pc_two;

    assign sum    = {1'b0, i_arch.acc} + {1'b0, i_arg};
    assign diff   = i_arch.acc - i_arg;
    assign pc_one = i_arch.pc + 8'd1;
    assign pc_two = i_arch.pc + 8'd2;

    // Execute one instruction; a stopped core keeps its state
    always_comb begin
        o_res         = '0;
        o_res.nxt     = i_arch;
        if (i_arch.status == RUN_ACTIVE) begin
            o_res.nxt.pc = pc_two;
            case (i_op)
                OP_NOP: begin
                    o_res.nxt.pc = pc_one;
                end
                OP_ADD: begin
                    o_res.nxt.acc   = sum[7:0];
                    o_res.nxt.carry = sum[8];
                    o_res.nxt.zero  = (sum[7:0] == 8'd0);
                end
                OP_SUB: begin
                    o_res.nxt.acc   = diff;
                    o_res.nxt.carry = (i_arch.acc < i_arg);
                    o_res.nxt.zero  = (diff == 8'd0);
                end
                OP_OUT: begin
                    o_res.port_wr = 1'b1;
                end
                OP_IN: begin
                    o_res.port_rd = 1'b1;
                end
                OP_JZ: begin
                    if (i_arch.zero) begin
                        o_res.nxt.pc = i_arg;
                    end
                end
                OP_JC: begin
                    if (i_arch.carry) begin
                        o_res.nxt.pc = i_arg;
                    end
                end
                OP_JMP: begin
                    o_res.nxt.pc = i_arg;
                end
                OP_HALT: begin
                    o_res.nxt.pc     = i_arch.pc;
                    o_res.nxt.status = RUN_HALTED;
                end
                default: begin
                    o_res.nxt.pc     = i_arch.pc;
                    o_res.nxt.status = RUN_INVALID;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/core/accumulator_cpu_step.sv
`default_nettype none
// A taken word's RAM read is registered; BUSY then registers its result word, or
// for IN issues a port read and PORT_WAIT registers it. Throughput: memory and port
// commands one word per cycle unless the output stalls; an execute word stalls input.
// Reset: synchronous, active low; clears the control registers and per-entry valid
// bits, so program memory and ports read as zero until written. No clearing pass.
// ----------------------------------------------------------------------------
// accumulator_cpu_step: 8-bit accumulator processor, one command per word
// Program memory and ports share one RAM with two read ports; a small
// sequencer reads, executes and writes back, one result word per command.
// ----------------------------------------------------------------------------
module accumulator_cpu_step
    import acpu_pkg::*;
#(
    parameter int unsigned MEM_DEPTH  = MEM_DEPTH_DEF,
    parameter int unsigned PORT_COUNT = PORT_COUNT_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_word      o_out_word
);

    localparam int unsigned RAM_DEPTH = MEM_DEPTH + PORT_COUNT;
    localparam int unsigned RAM_AW    = $clog2(RAM_DEPTH);
    localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);
    localparam int unsigned PORT_AW   = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam logic [RAM_AW-1:0] PORT_BASE = RAM_AW'(MEM_DEPTH);
    localparam t_mod_tbl MEM_MOD  = mod_table(MEM_DEPTH);
    localparam t_mod_tbl PORT_MOD = mod_table(PORT_COUNT);

    t_seq                  r_state, n_state;
    t_arch                 r_arch, n_arch;
    t_cmd                  r_cmd;
    logic [MEM_DEPTH-1:0]  r_pm_vld;
    logic [PORT_COUNT-1:0] r_pt_vld;
    logic                  r_vld0, n_vld0;
    logic                  r_vld1, n_vld1;
    logic                  r_out_valid, n_out_valid;
    t_out_word             r_out_word, n_out_word;

    logic              in_fire;
    logic              out_free;
    logic              exec_busy;
    logic              in_start;
    logic              s1_done;
    logic              s1_adv;
    logic              port_wr_go;
    logic [7:0]        byte0;
    logic [7:0]        byte1;
    logic [7:0]        pc_next1;
    logic [7:0]        pc_mem;
    logic [7:0]        pc1_mem;
    logic [7:0]        addr_mem;
    logic [7:0]        addr_port;
    logic [7:0]        arg_port;
    logic              ram_we;
    logic              ram_re;
    logic [RAM_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [RAM_AW-1:0] ram_raddr0;
    logic [RAM_AW-1:0] ram_raddr1;
    logic [7:0]        ram_rdata0;
    logic [7:0]        ram_rdata1;
    t_alu_res          alu_res;

    // Shared store: program bytes first, ports after them
    acpu_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_we     (ram_we),
        .i_waddr  (ram_waddr),
        .i_wdata  (ram_wdata),
        .i_re     (ram_re),
        .i_raddr0 (ram_raddr0),
        .i_raddr1 (ram_raddr1),
        .o_rdata0 (ram_rdata0),
        .o_rdata1 (ram_rdata1)
    );

    // Entries never written read as zero
    assign byte0 = r_vld0 ? ram_rdata0 : 8'd0;
    assign byte1 = r_vld1 ? ram_rdata1 : 8'd0;

    acpu_alu u_alu (
        .i_arch (r_arch),
        .i_op   (byte0),
        .i_arg  (byte1),
        .o_res  (alu_res)
    );

    // Wrap addresses into the program memory and port ranges
    assign pc_next1  = r_arch.pc + 8'd1;
    assign pc_mem    = MEM_MOD[r_arch.pc];
    assign pc1_mem   = MEM_MOD[pc_next1];
    assign addr_mem  = MEM_MOD[i_in_word.address];
    assign addr_port = PORT_MOD[i_in_word.address];
    assign arg_port  = PORT_MOD[byte1];

    // Handshake and stage control
    assign out_free  = !r_out_valid || !i_out_stall;
    assign exec_busy = (r_state == SEQ_BUSY) && (r_cmd == CMD_EXEC);
    assign in_start  = exec_busy && alu_res.port_rd;
    assign s1_adv    = s1_done && out_free;
    assign in_fire   = i_in_valid && !o_in_stall;
    assign port_wr_go = exec_busy && alu_res.port_wr && s1_adv;

    always_comb begin
        case (r_state)
            SEQ_EMPTY: begin
                s1_done    = 1'b0;
                o_in_stall = 1'b0;
            end
            SEQ_BUSY: begin
                s1_done    = !in_start;
                o_in_stall = exec_busy || !(s1_done && out_free);
            end
            SEQ_PORT_WAIT: begin
                s1_done    = 1'b1;
                o_in_stall = 1'b1;
            end
            default: begin
                s1_done    = 1'b0;
                o_in_stall = 1'b1;
            end
        endcase
    end

    // Next state of the sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            SEQ_EMPTY: begin
                if (in_fire) begin
                    n_state = SEQ_BUSY;
                end
            end
            SEQ_BUSY: begin
                if (in_start) begin
                    n_state = SEQ_PORT_WAIT;
                end else if (s1_adv) begin
                    n_state = in_fire ? SEQ_BUSY : SEQ_EMPTY;
                end
            end
            SEQ_PORT_WAIT: begin
                if (s1_adv) begin
                    n_state = SEQ_EMPTY;
                end
            end
            default: begin
                n_state = SEQ_EMPTY;
            end
        endcase
    end

    // Result word and register update of the finishing command
    always_comb begin
        n_arch     = r_arch;
        n_out_word = '0;
        case (r_state)
            SEQ_BUSY: begin
                if (r_cmd == CMD_EXEC) begin
                    n_arch = alu_res.nxt;
                    if (alu_res.port_wr) begin
                        n_out_word.port_write_valid = 1'b1;
                        n_out_word.port_write_index = arg_port[2:0];
                        n_out_word.port_write_value = r_arch.acc;
                    end
                end else if (r_cmd == CMD_PORT_RD) begin
                    n_out_word.read_value = byte0;
                end
            end
            SEQ_PORT_WAIT: begin
                n_arch.acc = byte0;
                n_arch.pc  = r_arch.pc + 8'd2;
            end
            default: begin
                n_arch = r_arch;
            end
        endcase
        n_out_word.acc_value  = n_arch.acc;
        n_out_word.pc_value   = n_arch.pc;
        n_out_word.carry_out  = n_arch.carry;
        n_out_word.zero_out   = n_arch.zero;
        n_out_word.run_status = n_arch.status;
    end

    // Hold the output word until taken
    assign n_out_valid = s1_adv || (r_out_valid && i_out_stall);

    // RAM read: opcode and operand fetch, port read, or IN port read
    always_comb begin
        ram_re     = in_fire || in_start;
        ram_raddr1 = RAM_AW'(pc1_mem);
        n_vld1     = r_pm_vld[pc1_mem[MEM_AW-1:0]];
        if (in_start) begin
            ram_raddr0 = PORT_BASE + RAM_AW'(arg_port);
            n_vld0     = r_pt_vld[arg_port[PORT_AW-1:0]];
        end else if (i_in_word.command == CMD_EXEC) begin
            ram_raddr0 = RAM_AW'(pc_mem);
            n_vld0     = r_pm_vld[pc_mem[MEM_AW-1:0]];
        end else begin
            ram_raddr0 = PORT_BASE + RAM_AW'(addr_port);
            n_vld0     = r_pt_vld[addr_port[PORT_AW-1:0]];
        end
    end

    // RAM write: memory byte, port byte, or OUT
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = RAM_AW'(addr_mem);
        ram_wdata = i_in_word.data;
        if (port_wr_go) begin
            ram_we    = 1'b1;
            ram_waddr = PORT_BASE + RAM_AW'(arg_port);
            ram_wdata = r_arch.acc;
        end else if (in_fire && (i_in_word.command == CMD_MEM_WR)) begin
            ram_we    = 1'b1;
            ram_waddr = RAM_AW'(addr_mem);
        end else if (in_fire && (i_in_word.command == CMD_PORT_WR)) begin
            ram_we    = 1'b1;
            ram_waddr = PORT_BASE + RAM_AW'(addr_port);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SEQ_EMPTY;
            r_arch      <= '0;
            r_pm_vld    <= '0;
            r_pt_vld    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (s1_adv) begin
                r_arch <= n_arch;
            end
            if (port_wr_go) begin
                r_pt_vld[arg_port[PORT_AW-1:0]] <= 1'b1;
            end
            if (in_fire && (i_in_word.command == CMD_MEM_WR)) begin
                r_pm_vld[addr_mem[MEM_AW-1:0]] <= 1'b1;
            end
            if (in_fire && (i_in_word.command == CMD_PORT_WR)) begin
                r_pt_vld[addr_port[PORT_AW-1:0]] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd <= i_in_word.command;
        end
        if (ram_re) begin
            r_vld0 <= n_vld0;
            r_vld1 <= n_vld1;
        end
        if (s1_adv) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
`default_nettype wire

### verif/accumulator_cpu_step_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: command-level check of the accumulator_cpu_step processor
// Runs a short hand-built program that walks every opcode but HALT, carry,
// borrow and zero flags and address wraps, then a long run of steered random
// programs, port traffic and memory writes, and ends by stopping the core on
// HALT or a bad opcode. Result words are compared with a cycle-free model kept
// here or a fixed row result. Both channels see random valid gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;
    import acpu_pkg::*;

    localparam int RANDOM_WORDS = 1900;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_LIMIT  = 40;

    typedef struct {
        t_in_word  word;
        bit        fixed;
        t_out_word result;
    } t_plan_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    // Processor state of the model
    logic [7:0] cpu_acc   = '0;
    logic [7:0] cpu_pc    = '0;
    logic       cpu_carry = 1'b0;
    logic       cpu_zero  = 1'b0;
    t_run       cpu_run   = RUN_ACTIVE;
    logic [7:0] prog_mem  [256];
    logic [7:0] port_bank [8];

    t_out_word  expected_states [$];
    t_plan_row  plan [$];
    int         mismatch_count = 0;
    int         cycle_count    = 0;
    int         stall_left     = 0;
    bit         gaps_on        = 1'b1;

    accumulator_cpu_step i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Apply one command word to the model and return the state it leaves
    function automatic t_out_word predict_cpu_step(input t_in_word w);
        t_out_word  r;
        logic [7:0] opc;
        logic [7:0] opd;
        logic [7:0] opd_addr;
        logic [7:0] nxt;
        logic [8:0] sum;
        r = '0;
        case (w.command)
            CMD_MEM_WR: prog_mem[w.address] = w.data;
            CMD_PORT_WR: port_bank[w.address[2:0]] = w.data;
            CMD_PORT_RD: r.read_value = port_bank[w.address[2:0]];
            default: begin
                if (cpu_run == RUN_ACTIVE) begin
                    opd_addr = cpu_pc + 8'd1;
                    opc      = prog_mem[cpu_pc];
                    opd      = prog_mem[opd_addr];
                    nxt      = cpu_pc + 8'd2;
                    case (opc)
                        OP_NOP: nxt = cpu_pc + 8'd1;
                        OP_ADD: begin
                            sum       = {1'b0, cpu_acc} + {1'b0, opd};
                            cpu_carry = sum[8];
                            cpu_acc   = sum[7:0];
                            cpu_zero  = (cpu_acc == 8'd0);
                        end
                        OP_SUB: begin
                            cpu_carry = (cpu_acc < opd);
                            cpu_acc   = cpu_acc - opd;
                            cpu_zero  = (cpu_acc == 8'd0);
                        end
                        OP_OUT: begin
                            port_bank[opd[2:0]]  = cpu_acc;
                            r.port_write_valid = 1'b1;
                            r.port_write_index = opd[2:0];
                            r.port_write_value = cpu_acc;
                        end
                        OP_IN: cpu_acc = port_bank[opd[2:0]];
                        OP_JZ: if (cpu_zero) nxt = opd;
                        OP_JC: if (cpu_carry) nxt = opd;
                        OP_JMP: nxt = opd;
                        OP_HALT: begin
                            cpu_run = RUN_HALTED;
                            nxt     = cpu_pc;
                        end
                        default: begin
                            cpu_run = RUN_INVALID;
                            nxt     = cpu_pc;
                        end
                    endcase
                    cpu_pc = nxt;
                end
            end
        endcase
        r.acc_value  = cpu_acc;
        r.pc_value   = cpu_pc;
        r.carry_out  = cpu_carry;
        r.zero_out   = cpu_zero;
        r.run_status = cpu_run;
        return r;
    endfunction

    // Pick a random command; keep a valid opcode under the PC so the core runs
    function automatic t_in_word pick_random_word();
        t_in_word w;
        int       sel;
        sel       = $urandom_range(0, 99);
        w.command = CMD_EXEC;
        w.address = 8'($urandom_range(0, 255));
        w.data    = 8'($urandom_range(0, 255));
        if (sel < 10) begin
            w.command = CMD_MEM_WR;
        end else if (sel < 16) begin
            w.command = CMD_MEM_WR;
            w.address = cpu_pc + 8'd1;
        end else if (sel < 23) begin
            w.command = CMD_PORT_WR;
        end else if (sel < 30) begin
            w.command = CMD_PORT_RD;
        end else if (prog_mem[cpu_pc] > OP_JMP || sel < 40) begin
            w.command = CMD_MEM_WR;
            w.address = cpu_pc;
            w.data    = 8'($urandom_range(0, 7));
        end
        return w;
    endfunction

    function automatic t_plan_row row(input t_cmd cmd, input logic [7:0] addr,
                                      input logic [7:0] dat, input bit fixed = 1'b0,
                                      input t_out_word res = '0);
        t_plan_row p;
        p.word   = '{cmd, addr, dat};
        p.fixed  = fixed;
        p.result = res;
        return p;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("%0t: %s got %h, want %h", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic check_word(input t_out_word got);
        t_out_word want;
        if (expected_states.size() == 0) begin
            report_mismatch("word with nothing pending, acc", got.acc_value, 8'h00);
        end else begin
            want = expected_states.pop_front();
            if (got.acc_value !== want.acc_value)
                report_mismatch("acc_value", got.acc_value, want.acc_value);
            if (got.pc_value !== want.pc_value)
                report_mismatch("pc_value", got.pc_value, want.pc_value);
            if (got.carry_out !== want.carry_out)
                report_mismatch("carry_out", 8'(got.carry_out), 8'(want.carry_out));
            if (got.zero_out !== want.zero_out)
                report_mismatch("zero_out", 8'(got.zero_out), 8'(want.zero_out));
            if (got.run_status !== want.run_status)
                report_mismatch("run_status", 8'(got.run_status), 8'(want.run_status));
            if (got.port_write_valid !== want.port_write_valid)
                report_mismatch("port_write_valid", 8'(got.port_write_valid),
                                8'(want.port_write_valid));
            if (got.port_write_index !== want.port_write_index)
                report_mismatch("port_write_index", 8'(got.port_write_index),
                                8'(want.port_write_index));
            if (got.port_write_value !== want.port_write_value)
                report_mismatch("port_write_value", got.port_write_value,
                                want.port_write_value);
            if (got.read_value !== want.read_value)
                report_mismatch("read_value", got.read_value, want.read_value);
        end
    endtask

    // Offer one word, hold it through stalls, record its expectation on accept
    task automatic send_word(input t_in_word w, input bit fixed, input t_out_word res);
        t_out_word predicted;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_word  <= w;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        predicted = predict_cpu_step(w);
        expected_states.push_back(fixed ? res : predicted);
    endtask

    // Drop valid and wait for every pending result word
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_states.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Check accepted result words and drive random stall bursts
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_word(o_out_word);
        end
        if (stall_left != 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (gaps_on && i_rst_n && $urandom_range(0, 4) == 0) begin
            stall_left  = $urandom_range(0, 2);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("accumulator_cpu_step: mismatch");
            $finish;
        end
    end

    initial begin
        t_in_word   w;
        logic [7:0] stop_op;
        foreach (prog_mem[i]) prog_mem[i] = '0;
        foreach (port_bank[i]) port_bank[i] = '0;

        // Hand-built program: reset state, every opcode but HALT, flags, wraps
        plan.push_back(row(CMD_PORT_RD, 8'hFF, 8'h00, 1'b1,
            '{8'h00, 8'h00, 1'b0, 1'b0, RUN_ACTIVE, 1'b0, 3'd0, 8'h00, 8'h00}));
        plan.push_back(row(CMD_EXEC, 8'h00, 8'h00, 1'b1,
            '{8'h00, 8'h01, 1'b0, 1'b0, RUN_ACTIVE, 1'b0, 3'd0, 8'h00, 8'h00}));
        // SUB 1 from zero: borrow
        plan.push_back(row(CMD_MEM_WR, 8'h01, OP_SUB));
        plan.push_back(row(CMD_MEM_WR, 8'h02, 8'h01));
        plan.push_back(row(CMD_EXEC, 8'h00, 8'h00, 1'b1,
            '{8'hFF, 8'h03, 1'b1, 1'b0, RUN_ACTIVE, 1'b0, 3'd0, 8'h00, 8'h00}));
        // JC taken
        plan.push_back(row(CMD_MEM_WR, 8'h03, OP_JC));
        plan.push_back(row(CMD_MEM_WR, 8'h04, 8'hF0));
        plan.push_back(row(CMD_EXEC, 8'h00, 8'h00));
        // ADD 1 to 0xFF: carry and zero
        plan.push_back(row(CMD_MEM_WR, 8'hF0, OP_ADD));
        plan.push_back(row(CMD_MEM_WR, 8'hF1, 8'h01));
        plan.push_back(row(CMD_EXEC, 8'h00, 8'h00, 1'b1,
            '{8'h00, 8'hF2, 1'b1, 1'b1, RUN_ACTIVE, 1'b0, 3'd0, 8'h00, 8'h00}));
        // JZ taken to the last byte
        plan.push_back(row(CMD_MEM_WR, 8'hF2, OP_JZ));
        plan.push_back(row(CMD_MEM_WR, 8'hF3, 8'hFF));
        plan.push_back(row(CMD_EXEC, 8'h00, 8'h00));
        // IN at 0xFF: operand fetch and PC both wrap, port number uses low bits
        plan.push_back(row(CMD_MEM_WR, 8'hFF, OP_IN));
        plan.push_back(row(CMD_MEM_WR, 8'h00, 8'hFD));
        plan.push_back(row(CMD_PORT_WR, 8'hFD, 8'hA5));
        plan.push_back(row(CMD_EXEC, 8'h00, 8'h00));
        // SUB again without borrow, then JC not taken
        plan.push_back(row(CMD_EXEC, 8'h00, 8'h00));
        plan.push_back(row(CMD_EXEC, 8'h00, 8'h00));
        // OUT to port 6 through a wide port number
        plan.push_back(row(CMD_MEM_WR, 8'h05, OP_OUT));
        plan.push_back(row(CMD_MEM_WR, 8'h06, 8'h0E));
        plan.push_back(row(CMD_EXEC, 8'h00, 8'h00));
        // JMP
        plan.push_back(row(CMD_MEM_WR, 8'h07, OP_JMP));
        plan.push_back(row(CMD_MEM_WR, 8'h08, 8'h80));
        plan.push_back(row(CMD_EXEC, 8'h00, 8'h00));
        plan.push_back(row(CMD_PORT_RD, 8'h0E, 8'h00));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) send_word(plan[i].word, plan[i].fixed, plan[i].result);
        drain_results();

        // Random programs; idling comes and goes in blocks, none at the end
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 100 == 0) begin
                gaps_on = (n < RANDOM_WORDS - 300) ? ($urandom_range(0, 3) != 0) : 1'b0;
            end
            if (n == RANDOM_WORDS / 2) begin
                drain_results();
            end
            send_word(pick_random_word(), 1'b0, '0);
        end

        // Stop the core, then show that only commands other than execute act
        stop_op = $urandom_range(0, 1) ? OP_HALT : 8'($urandom_range(8, 254));
        w = '{CMD_MEM_WR, cpu_pc, stop_op};
        send_word(w, 1'b0, '0);
        w = '{CMD_EXEC, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
        send_word(w, 1'b0, '0);
        send_word(w, 1'b0, '0);
        send_word(pick_random_word(), 1'b0, '0);
        w = '{CMD_MEM_WR, cpu_pc, OP_NOP};
        send_word(w, 1'b0, '0);
        w = '{CMD_PORT_WR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
        send_word(w, 1'b0, '0);
        w.command = CMD_PORT_RD;
        send_word(w, 1'b0, '0);
        w.command = CMD_EXEC;
        send_word(w, 1'b0, '0);

        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("accumulator_cpu_step: match");
        end else begin
            $display("accumulator_cpu_step: mismatch");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/acpu_pkg.sv
rtl/core/acpu_ram.sv
rtl/core/acpu_alu.sv
rtl/core/accumulator_cpu_step.sv
verif/accumulator_cpu_step_tb.sv
